// File: design/tmt_pkg.sv
// shared types, constants and state-update functions of the tinymt32 generator
// no dependencies
`default_nettype none

package tmt_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned SeedW    = 8;
  localparam int unsigned NumWords = 4;
  localparam int unsigned MinLoop  = 8;
  localparam int unsigned PreLoop  = 8;
  localparam int unsigned CntW     = $clog2(WordW);
  localparam int unsigned LoopW    = $clog2(MinLoop);

  localparam logic [WordW-1:0] MtMask   = 32'h7fff_ffff;
  localparam logic [WordW-1:0] MtMult   = 32'd1812433253;
  localparam logic [SeedW-1:0] ZeroSeed = 8'd110;
  localparam logic [WordW-1:0] FillB    = 32'd66;
  localparam logic [WordW-1:0] FillA    = 32'd65;
  localparam logic [WordW-1:0] FillY    = 32'd89;
  localparam logic [WordW-1:0] FillS    = 32'd83;

  localparam logic OpReseed   = 1'b0;
  localparam logic OpGenerate = 1'b1;

  typedef logic [NumWords-1:0][WordW-1:0] words_t;

  typedef enum logic [3:0] {
    StIdle,
    StMixStart,
    StMixWait,
    StZeroChk,
    StPreAdv,
    StGenAdv,
    StDivStart,
    StDivWait,
    StDone
  } state_e;

  // one state advance
  function automatic words_t tmt_advance(words_t w, logic [SeedW-1:0] mix_a,
                                         logic [SeedW-1:0] mix_b);
    logic [WordW-1:0] x;
    logic [WordW-1:0] y;
    logic [SeedW-1:0] fill;
    words_t           n;
    x    = (w[0] & MtMask) ^ w[1] ^ w[2];
    x    = x ^ (x << 1);
    y    = w[3] ^ (w[3] >> 1) ^ x;
    fill = {SeedW{y[0]}};
    n[0] = w[1];
    n[1] = w[2] ^ {{(WordW-SeedW){1'b0}}, fill & mix_a};
    n[2] = x ^ (y << 10) ^ {{(WordW-SeedW){1'b0}}, fill & mix_b};
    n[3] = y;
    return n;
  endfunction

  // output tempering
  function automatic logic [WordW-1:0] tmt_temper(words_t w, logic [SeedW-1:0] tw);
    logic [WordW-1:0] t1;
    t1 = w[0] ^ (w[2] >> 8);
    return w[3] ^ t1 ^ {{(WordW-SeedW){1'b0}}, {SeedW{t1[0]}} & tw};
  endfunction

endpackage

`default_nettype wire

// File: design/tmt_serial_mul.sv
// shift-add multiplier, one multiplier bit per cycle, product kept modulo 2^32
// depends on tmt_pkg
`default_nettype none

module tmt_serial_mul
  import tmt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WordW-1:0] mcand_i,
  input  logic [WordW-1:0] mplier_i,
  output logic             done_o,
  output logic [WordW-1:0] prod_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WordW-1:0] acc_q, acc_d;
  logic [WordW-1:0] mcand_q, mcand_d;
  logic [WordW-1:0] mplier_q, mplier_d;

  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    if (start_i) begin
      busy_d   = 1'b1;
      cnt_d    = '0;
      acc_d    = '0;
      mcand_d  = mcand_i;
      mplier_d = mplier_i;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        acc_d = acc_q + mcand_q;
      end
      mcand_d  = mcand_q << 1;
      mplier_d = mplier_q >> 1;
      cnt_d    = cnt_q + 1'b1;
      if (cnt_q == CntW'(WordW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

// File: design/tmt_serial_mod.sv
// restoring remainder unit, one quotient bit per cycle
// depends on tmt_pkg
`default_nettype none

module tmt_serial_mod
  import tmt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WordW-1:0] dividend_i,
  input  logic [WordW-1:0] divisor_i,
  output logic             done_o,
  output logic [WordW-1:0] rem_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WordW-1:0] num_q, num_d;
  logic [WordW-1:0] rem_q, rem_d;
  logic [WordW-1:0] div_q, div_d;
  logic [WordW:0]   trial;
  logic [WordW:0]   diff;

  // partial remainder stays below the divisor, so the trial fits in one extra bit
  assign trial = {rem_q, num_q[WordW-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = diff[WordW] ? trial[WordW-1:0] : diff[WordW-1:0];
      num_d = num_q << 1;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(WordW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// File: design/tinymt32_random_generator.sv
// top level of the tinymt32 generator: control sequencer, state words, seed registers
// depends on tmt_pkg, tmt_serial_mul and tmt_serial_mod
`default_nettype none

// TinyMT32-style random generator with a reseed request and a bounded generate
// request. Four seed bytes are written over the APB-style port (byte addresses
// 0, 4, 8, 12; a zero byte stands for 110). A request with op_i = 0 reseeds:
// seven multiply-xor mixing steps, each done by a shift-add multiplier one bit
// per cycle, a zero-state check and eight state advances, and returns value 0.
// A request with op_i = 1 advances the state once, tempers it and reduces it
// modulo modulus_i in a restoring remainder unit that yields one quotient bit
// per cycle; a zero modulus skips the remainder unit, returns 0 and raises
// modulus_zero_o. One request is worked at a time; the result sits in an
// output register, so the next request is taken while the previous result
// waits to be read.
module tinymt32_random_generator
  import tmt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // request channel
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             op_i,
  input  logic [WordW-1:0] modulus_i,
  // result channel
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [WordW-1:0] value_o,
  output logic             modulus_zero_o
);

  // seed registers
  logic [NumWords-1:0][SeedW-1:0] seed_q;
  logic [1:0]                     cfg_idx;
  logic                           cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = {{(32-SeedW){1'b0}}, seed_q[cfg_idx]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_wr) begin
      seed_q[cfg_idx] <= pwdata[SeedW-1:0];
    end
  end

  // generator state and sequencer
  state_e           state_q, state_d;
  words_t           words_q, words_d;
  logic [SeedW-1:0] mix_a_q, mix_a_d;
  logic [SeedW-1:0] mix_b_q, mix_b_d;
  logic [SeedW-1:0] temper_q, temper_d;
  logic [LoopW-1:0] mix_idx_q, mix_idx_d;
  logic [LoopW-1:0] loop_q, loop_d;
  logic [WordW-1:0] mod_q, mod_d;
  logic [WordW-1:0] res_value_q, res_value_d;
  logic             res_mz_q, res_mz_d;
  logic             out_valid_q, out_valid_d;
  logic [WordW-1:0] out_value_q, out_value_d;
  logic             out_mz_q, out_mz_d;

  logic [NumWords-1:0][SeedW-1:0] seed_eff;
  words_t           adv_words;
  words_t           aligned;
  logic [WordW-1:0] prev_mix;
  logic [WordW-1:0] mixed_word;
  logic             mul_start, mul_done;
  logic [WordW-1:0] mul_prod;
  logic             div_start, div_done;
  logic [WordW-1:0] div_rem;

  // a zero seed byte stands for the default seed
  always_comb begin
    for (int i = 0; i < NumWords; i++) begin
      seed_eff[i] = (seed_q[i] == '0) ? ZeroSeed : seed_q[i];
    end
  end

  assign adv_words = tmt_advance(words_q, mix_a_q, mix_b_q);

  // the mixing pass rotates the words once per step, so the previous word is
  // always word 0 and the target always word 1
  assign prev_mix   = words_q[0] ^ (words_q[0] >> 30);
  assign mixed_word = words_q[1] ^ (mul_prod + {{(WordW-LoopW){1'b0}}, mix_idx_q});

  // after seven rotations one more puts the words back in their own places
  always_comb begin
    aligned[0] = words_q[1];
    aligned[1] = words_q[2];
    aligned[2] = words_q[3];
    aligned[3] = words_q[0];
  end

  always_comb begin
    state_d     = state_q;
    words_d     = words_q;
    mix_a_d     = mix_a_q;
    mix_b_d     = mix_b_q;
    temper_d    = temper_q;
    mix_idx_d   = mix_idx_q;
    loop_d      = loop_q;
    mod_d       = mod_q;
    res_value_d = res_value_q;
    res_mz_d    = res_mz_q;
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;
    out_mz_d    = out_mz_q;
    mul_start   = 1'b0;
    div_start   = 1'b0;
    in_stall_o  = 1'b1;

    // result taken downstream
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          mod_d = modulus_i;
          if (op_i == OpGenerate) begin
            state_d = StGenAdv;
          end else begin
            for (int i = 0; i < NumWords; i++) begin
              words_d[i] = {{(WordW-SeedW){1'b0}}, seed_eff[i]};
            end
            mix_a_d   = seed_eff[1];
            mix_b_d   = seed_eff[2];
            temper_d  = seed_eff[3];
            mix_idx_d = LoopW'(1);
            state_d   = StMixStart;
          end
        end
      end
      StMixStart: begin
        mul_start = 1'b1;
        state_d   = StMixWait;
      end
      StMixWait: begin
        if (mul_done) begin
          words_d[0] = mixed_word;
          words_d[1] = words_q[2];
          words_d[2] = words_q[3];
          words_d[3] = words_q[0];
          mix_idx_d  = mix_idx_q + 1'b1;
          state_d    = (mix_idx_q == LoopW'(MinLoop - 1)) ? StZeroChk : StMixStart;
        end
      end
      StZeroChk: begin
        if ((aligned[0] & MtMask) == '0 && aligned[1] == '0 &&
            aligned[2] == '0 && aligned[3] == '0) begin
          words_d[0] = FillB;
          words_d[1] = FillA;
          words_d[2] = FillY;
          words_d[3] = FillS;
        end else begin
          words_d = aligned;
        end
        loop_d  = '0;
        state_d = StPreAdv;
      end
      StPreAdv: begin
        words_d = adv_words;
        loop_d  = loop_q + 1'b1;
        if (loop_q == LoopW'(PreLoop - 1)) begin
          res_value_d = '0;
          res_mz_d    = 1'b0;
          state_d     = StDone;
        end
      end
      StGenAdv: begin
        words_d = adv_words;
        state_d = StDivStart;
      end
      StDivStart: begin
        if (mod_q == '0) begin
          res_value_d = '0;
          res_mz_d    = 1'b1;
          state_d     = StDone;
        end else begin
          div_start = 1'b1;
          state_d   = StDivWait;
        end
      end
      StDivWait: begin
        if (div_done) begin
          res_value_d = div_rem;
          res_mz_d    = 1'b0;
          state_d     = StDone;
        end
      end
      StDone: begin
        // wait for a free output register
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_value_d = res_value_q;
          out_mz_d    = res_mz_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      words_q     <= '0;
      mix_a_q     <= '0;
      mix_b_q     <= '0;
      temper_q    <= '0;
      mix_idx_q   <= '0;
      loop_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      words_q     <= words_d;
      mix_a_q     <= mix_a_d;
      mix_b_q     <= mix_b_d;
      temper_q    <= temper_d;
      mix_idx_q   <= mix_idx_d;
      loop_q      <= loop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mod_q       <= mod_d;
    res_value_q <= res_value_d;
    res_mz_q    <= res_mz_d;
    out_value_q <= out_value_d;
    out_mz_q    <= out_mz_d;
  end

  tmt_serial_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (MtMult),
    .mplier_i (prev_mix),
    .done_o   (mul_done),
    .prod_o   (mul_prod)
  );

  tmt_serial_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (tmt_temper(words_q, temper_q)),
    .divisor_i  (mod_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign out_valid_o    = out_valid_q;
  assign value_o        = out_value_q;
  assign modulus_zero_o = out_mz_q;

  // multiplier finishes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == StMixWait)
    else $error("multiplier done outside mixing wait");

  // remainder unit finishes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == StDivWait)
    else $error("remainder done outside remainder wait");

  // mixing steps never run with a zero step index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StMixStart |-> mix_idx_q != '0)
    else $error("mixing step index is zero");

  // a zero-modulus result always carries value 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && modulus_zero_o) |-> value_o == '0)
    else $error("zero-modulus result with nonzero value");

  // a fresh generate result is below its modulus
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_o) && !modulus_zero_o && mod_q != '0 && res_mz_q == 1'b0 &&
     $past(state_q) == StDone && $past(res_value_q) != '0) |-> value_o < mod_q)
    else $error("remainder not below modulus");

endmodule

`default_nettype wire
